// File: design/sed_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; all files but sed_ram and sed_div import it.
package sed_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int SUM_BITS       = PIXEL_BITS + 2;
  localparam int EDGE_BITS      = 11;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 13;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 13;
  localparam int OFIFO_DEPTH    = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } sed_tag_t;

  typedef struct packed {
    logic                 last;
    logic [EDGE_BITS-1:0] strength;
  } sed_result_t;

endpackage

// File: design/sed_if.sv
`timescale 1ns / 1ps
// Channel interfaces: pixel requests, edge results and register writes.
// Depends on sed_pkg.
interface sed_in_if import sed_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   mode;
  pixel_t pixel;
  modport source (output valid, mode, pixel, input ready);
  modport sink (input valid, mode, pixel, output ready);
endinterface

interface sed_out_if import sed_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [EDGE_BITS-1:0] edge_strength;
  logic                 frame_last;
  modport source (output valid, edge_strength, frame_last, input ready);
  modport sink (input valid, edge_strength, frame_last, output ready);
endinterface

interface sed_cfg_if import sed_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/sed_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module sed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sed_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used to rebuild row and column of the result count.
module sed_div #(
  parameter int NUM_BITS = 22,
  parameter int DEN_BITS = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quo,
  output logic [DEN_BITS-1:0] rem
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS:0]   part;
  logic [DEN_BITS-1:0] den_r;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  always_comb begin
    shifted = {part[DEN_BITS-1:0], quo[NUM_BITS-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      part  <= '0;
      den_r <= den;
    end else if (busy) begin
      quo  <= {quo[NUM_BITS-2:0], ge};
      part <= ge ? diff : shifted;
    end
  end

  assign rem = part[DEN_BITS-1:0];

endmodule

// File: design/sed_kernel.sv
`timescale 1ns / 1ps
// 3x3 window taps, border masking and |Gx|+|Gy| pipeline.
// Depends on sed_pkg.
module sed_kernel import sed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  sed_tag_t    in_tag,
  input  pixel_t      upper,
  input  pixel_t      lower,
  input  pixel_t      center,
  output logic        push,
  output sed_result_t result
);

  pixel_t   taps [3][3];
  pixel_t   m [3][3];
  logic     s2_valid;
  logic     s3_valid;
  sed_tag_t s2_tag;
  sed_tag_t s3_tag;
  logic [SUM_BITS-1:0] gx_p, gx_n, gy_p, gy_n;
  logic [SUM_BITS-1:0] ax_next, ay_next;
  logic [SUM_BITS-1:0] ax, ay;
  pixel_t col_in [3];

  function automatic logic [SUM_BITS-1:0] wsum(pixel_t a, pixel_t b, pixel_t c);
    wsum = SUM_BITS'(a) + (SUM_BITS'(b) << 1) + SUM_BITS'(c);
  endfunction

  assign col_in[0] = upper;
  assign col_in[1] = lower;
  assign col_in[2] = center;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          taps[i][j] <= '0;
        end
      end
    end else if (in_valid) begin
      for (int i = 0; i < 3; i++) begin
        taps[i][0] <= taps[i][1];
        taps[i][1] <= taps[i][2];
        taps[i][2] <= col_in[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = taps[i][j];
      end
    end
    if (s2_tag.top) begin
      for (int j = 0; j < 3; j++) m[0][j] = '0;
    end
    if (s2_tag.bottom) begin
      for (int j = 0; j < 3; j++) m[2][j] = '0;
    end
    if (s2_tag.left) begin
      for (int i = 0; i < 3; i++) m[i][0] = '0;
    end
    if (s2_tag.right) begin
      for (int i = 0; i < 3; i++) m[i][2] = '0;
    end
    gx_p    = wsum(m[0][2], m[1][2], m[2][2]);
    gx_n    = wsum(m[0][0], m[1][0], m[2][0]);
    gy_p    = wsum(m[0][0], m[0][1], m[0][2]);
    gy_n    = wsum(m[2][0], m[2][1], m[2][2]);
    ax_next = (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
    ay_next = (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s2_tag <= in_tag;
    end
    s3_tag <= s2_tag;
    ax     <= ax_next;
    ay     <= ay_next;
  end

  assign push            = s3_valid && s3_tag.emit;
  assign result.last     = s3_tag.last;
  assign result.strength = EDGE_BITS'(ax) + EDGE_BITS'(ay);

endmodule

// File: design/sed_ofifo.sv
`timescale 1ns / 1ps
// Result queue with credit tracking for results still in the pipeline.
// Depends on sed_pkg and sed_if.
module sed_ofifo import sed_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         reserve,
  input  logic         push,
  input  sed_result_t  wdata,
  output logic         room,
  sed_out_if.source    results
);

  localparam int PTR_BITS = $clog2(OFIFO_DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;

  sed_result_t         slots [OFIFO_DEPTH];
  logic [PTR_BITS-1:0] head;
  logic [PTR_BITS-1:0] tail;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] reserved;
  logic [CNT_BITS:0]   claimed;
  logic                pop;

  assign pop     = results.valid && results.ready;
  assign claimed = (CNT_BITS + 1)'(count) + (CNT_BITS + 1)'(reserved);
  assign room    = claimed < (CNT_BITS + 1)'(OFIFO_DEPTH);

  assign results.valid         = count != '0;
  assign results.edge_strength = slots[head].strength;
  assign results.frame_last    = slots[head].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      reserved <= '0;
    end else begin
      if (push) begin
        tail <= tail + PTR_BITS'(1);
      end
      if (pop) begin
        head <= head + PTR_BITS'(1);
      end
      count    <= count + CNT_BITS'(push) - CNT_BITS'(pop);
      reserved <= reserved + CNT_BITS'(reserve) - CNT_BITS'(push);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wdata;
    end
  end

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    push |-> reserved != '0)
    else $error("result pushed without a reserved slot");

  a_no_overcommit: assert property (@(posedge clk) disable iff (rst)
    claimed <= (CNT_BITS + 1)'(OFIFO_DEPTH))
    else $error("queue slots overcommitted");

endmodule

// File: design/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// Channel   | Dir | Payload                         | Request when
// pixels    | in  | mode, pixel                     | valid && ready
// results   | out | edge_strength, frame_last       | valid && ready
// cfg       | in  | index, data (image_width/height)| valid && ready, ready always high
//
// One pixel request per cycle while pixels are not held off and the queue has
// room; the request that completes a window sends its result through line store
// read, tap shift, gradients and sum. The line stores share one RAM, read and
// written back once per request. After reset the line store RAM is cleared,
// min(MAX_WIDTH, 2047) entries, one entry a cycle; pixels are held off meanwhile.
// A width write holds off pixels while the result row and column are rebuilt
// by a bit-serial divider. Results queue in 8 slots.
// Depends on sed_pkg, sed_if, sed_ram, sed_div, sed_kernel, sed_ofifo.
module sobel_edge_magnitude import sed_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic      clk,
  input  logic      rst,
  sed_in_if.sink    pixels,
  sed_out_if.source results,
  sed_cfg_if.sink   cfg
);

  localparam int WCAP     = (MAX_WIDTH < (1 << WIDTH_BITS) - 1) ? MAX_WIDTH
                                                               : (1 << WIDTH_BITS) - 1;
  localparam int COL_BITS = $clog2(WCAP);
  localparam int QB       = $clog2(WCAP * HEIGHT_LIMIT);
  localparam int WX       = WIDTH_BITS + 1;
  localparam int EX       = QB + 1;
  localparam int WORD     = 2 * PIXEL_BITS;

  logic [WIDTH_BITS-1:0]  width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  logic [WIDTH_BITS-1:0]  eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;

  logic [COL_BITS-1:0] col;
  logic [1:0]          row;
  logic [COL_BITS-1:0] ec;
  logic [QB-1:0]       er;
  logic [QB-1:0]       q;

  logic                clearing;
  logic [COL_BITS-1:0] clr_addr;

  logic          div_go;
  logic          div_busy;
  logic          div_done;
  logic [QB-1:0] div_quo;
  logic [WIDTH_BITS-1:0] div_rem;
  logic          hold;
  logic          room;
  logic          accept;

  sed_tag_t tag0;
  logic     col_wrap;
  logic     ec_wrap;
  logic     er_ge_h;
  logic     er1_ge_h;
  pixel_t   v0;

  logic                s1_valid;
  sed_tag_t            s1_tag;
  pixel_t              s1_v;
  logic [COL_BITS-1:0] s1_addr;
  logic                fwd_hit;
  logic [WORD-1:0]     fwd_word;
  logic [WORD-1:0]     ram_rdata;
  logic [WORD-1:0]     cur_word;
  logic [WORD-1:0]     wr_word;
  logic                ram_we;
  logic [COL_BITS-1:0] ram_waddr;
  logic [WORD-1:0]     ram_wdata;

  logic        push;
  sed_result_t result;

  // Effective frame geometry
  always_comb begin
    if (width_reg == '0) begin
      eff_w = WIDTH_BITS'(1);
    end else if (width_reg > WIDTH_BITS'(WCAP)) begin
      eff_w = WIDTH_BITS'(WCAP);
    end else begin
      eff_w = width_reg;
    end
    if (height_reg == '0) begin
      eff_h = HEIGHT_BITS'(1);
    end else if (height_reg > HEIGHT_BITS'(HEIGHT_LIMIT)) begin
      eff_h = HEIGHT_BITS'(HEIGHT_LIMIT);
    end else begin
      eff_h = height_reg;
    end
  end

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_BITS'(WIDTH_RESET);
      height_reg <= HEIGHT_BITS'(HEIGHT_RESET);
      div_go     <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_IMAGE_WIDTH) begin
          width_reg <= cfg.data[WIDTH_BITS-1:0];
          div_go    <= 1'b1;
        end else if (cfg.index == CFG_IMAGE_HEIGHT) begin
          height_reg <= cfg.data[HEIGHT_BITS-1:0];
        end
      end
    end
  end

  sed_div #(
    .NUM_BITS (QB),
    .DEN_BITS (WIDTH_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (q),
    .den   (eff_w),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign hold         = clearing || div_go || div_busy || div_done;
  assign pixels.ready = !hold && room;
  assign accept       = pixels.valid && pixels.ready;

  // Request decode: emit decision and border flags for the result it completes
  always_comb begin
    v0          = pixels.mode ? '0 : pixels.pixel;
    col_wrap    = (WX'(col) + WX'(1)) >= WX'(eff_w);
    ec_wrap     = (WX'(ec) + WX'(1)) >= WX'(eff_w);
    er_ge_h     = EX'(er) >= EX'(eff_h);
    er1_ge_h    = (EX'(er) + EX'(1)) >= EX'(eff_h);
    tag0.emit   = !(((row == 2'd0) && (WX'(col) <= WX'(eff_w)))
                    || ((row == 2'd1) && (col == '0)));
    tag0.last   = ec_wrap ? er1_ge_h : er_ge_h;
    tag0.top    = er == '0;
    tag0.bottom = er1_ge_h;
    tag0.left   = ec == '0;
    tag0.right  = ec_wrap;
  end

  // Position and result counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ec  <= '0;
      er  <= '0;
      q   <= '0;
    end else if (div_done) begin
      er <= div_quo;
      ec <= div_rem[COL_BITS-1:0];
    end else if (accept) begin
      if (tag0.emit && tag0.last) begin
        col <= '0;
        row <= '0;
        ec  <= '0;
        er  <= '0;
        q   <= '0;
      end else begin
        if (col_wrap) begin
          col <= '0;
          if (row != 2'd2) begin
            row <= row + 2'd1;
          end
        end else begin
          col <= col + COL_BITS'(1);
        end
        if (tag0.emit) begin
          q <= q + QB'(1);
          if (ec_wrap) begin
            ec <= '0;
            er <= er + QB'(1);
          end else begin
            ec <= ec + COL_BITS'(1);
          end
        end
      end
    end
  end

  // Line store clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_BITS'(1);
      if (clr_addr == COL_BITS'(WCAP - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Line store read-modify-write, upper sample in the high half
  assign cur_word  = fwd_hit ? fwd_word : ram_rdata;
  assign wr_word   = {cur_word[PIXEL_BITS-1:0], s1_v};
  assign ram_we    = clearing || s1_valid;
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : wr_word;

  sed_ram #(
    .WIDTH (WORD),
    .DEPTH (WCAP)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag   <= tag0;
      s1_v     <= v0;
      s1_addr  <= col;
      fwd_hit  <= s1_valid && (s1_addr == col);
      fwd_word <= wr_word;
    end
  end

  sed_kernel u_kernel (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_tag   (s1_tag),
    .upper    (cur_word[WORD-1:PIXEL_BITS]),
    .lower    (cur_word[PIXEL_BITS-1:0]),
    .center   (s1_v),
    .push     (push),
    .result   (result)
  );

  sed_ofifo u_ofifo (
    .clk     (clk),
    .rst     (rst),
    .reserve (accept && tag0.emit),
    .push    (push),
    .wdata   (result),
    .room    (room),
    .results (results)
  );

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !clearing)
    else $error("line store write during clear");

  a_ec_in_row: assert property (@(posedge clk) disable iff (rst)
    !hold |-> WX'(ec) < WX'(eff_w))
    else $error("result column outside row");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && tag0.emit && tag0.last |=> (col == '0) && (row == '0) && (q == '0))
    else $error("frame counters not cleared after last result");

endmodule

// File: sim/tb_sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude: directed and random pixel frames,
// predicted edge results compared field by field as they leave the block.
// Depends on sed_pkg, the sed_if channel interfaces and the block's RTL.
module tb_sobel_edge_magnitude;
  import sed_pkg::*;

  localparam int LINE_DEPTH      = 1024;
  localparam int RANDOM_REQUESTS = 750;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 300;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

  typedef struct packed {
    logic   mode;
    pixel_t pixel;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sed_in_if  pix_ch ();
  sed_out_if res_ch ();
  sed_cfg_if cfg_ch ();

  sobel_edge_magnitude #(.MAX_WIDTH(LINE_DEPTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Edge predictor state
  logic [WIDTH_BITS-1:0]  width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  pixel_t                 upper_row [LINE_DEPTH];
  pixel_t                 lower_row [LINE_DEPTH];
  pixel_t                 window [3][3];
  int unsigned            frame_col;
  int unsigned            frame_row;
  int unsigned            result_index;

  pixel_req_t  pending_pixels [$];
  sed_result_t expected_edges [$];

  int unsigned requests_taken;
  int unsigned queued_total;
  int unsigned edges_checked;
  int unsigned frames_closed;
  int unsigned mismatches;
  int unsigned reg_writes;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  bit          in_fired;
  bit          hold_request;
  bit          results_held;

  function automatic int unsigned eff_width();
    if (width_reg == '0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == '0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic void clear_model();
    width_reg    = WIDTH_RESET;
    height_reg   = HEIGHT_RESET;
    frame_col    = 0;
    frame_row    = 0;
    result_index = 0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        window[a][b] = '0;
  endfunction

  // Advance the raster position by one request; report whether it emits a result.
  function automatic void step_position(inout int unsigned c, r, q,
                                        input int unsigned w, h,
                                        output bit emit, last,
                                        output int unsigned index);
    longint unsigned pos;
    pos = 64'(r) * 64'(w) + 64'(c);
    if (c + 1 >= w) begin
      c = 0;
      r++;
    end else begin
      c++;
    end
    emit  = (pos >= 64'(w) + 1);
    last  = 1'b0;
    index = q;
    if (emit) begin
      last = (64'(q) + 1 >= 64'(w) * 64'(h));
      if (last) begin
        q = 0;
        c = 0;
        r = 0;
      end else begin
        q++;
      end
    end
  endfunction

  function automatic void predict_edge(pixel_req_t req);
    int unsigned w, h, c, q;
    pixel_t      v;
    pixel_t      column [3];
    int          t [3][3];
    int          gx, gy;
    bit          emit, last, top, bottom, left, right;
    sed_result_t want;
    w = eff_width();
    h = eff_height();
    v = (req.mode == MODE_FLUSH) ? '0 : req.pixel;
    c = frame_col;
    column[0] = '0;
    column[1] = '0;
    if (c < LINE_DEPTH) begin
      column[0]    = upper_row[c];
      column[1]    = lower_row[c];
      upper_row[c] = lower_row[c];
      lower_row[c] = v;
    end
    column[2] = v;
    for (int i = 0; i < 3; i++) begin
      window[i][0] = window[i][1];
      window[i][1] = window[i][2];
      window[i][2] = column[i];
    end
    step_position(frame_col, frame_row, result_index, w, h, emit, last, q);
    if (emit) begin
      top    = (q / w == 0);
      bottom = (q / w + 1 >= h);
      left   = (q % w == 0);
      right  = (q % w + 1 >= w);
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          t[a][b] = window[a][b];
      for (int k = 0; k < 3; k++) begin
        if (top) t[0][k] = 0;
        if (bottom) t[2][k] = 0;
        if (left) t[k][0] = 0;
        if (right) t[k][2] = 0;
      end
      gx = (t[0][2] + 2 * t[1][2] + t[2][2]) - (t[0][0] + 2 * t[1][0] + t[2][0]);
      gy = (t[0][0] + 2 * t[0][1] + t[0][2]) - (t[2][0] + 2 * t[2][1] + t[2][2]);
      want.strength = EDGE_BITS'((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy));
      want.last     = last;
      expected_edges.push_back(want);
    end
  endfunction

  function automatic int unsigned items_to_frame_end();
    int unsigned c, r, q, w, h, index, n;
    bit          emit, last;
    c = frame_col;
    r = frame_row;
    q = result_index;
    w = eff_width();
    h = eff_height();
    n = 0;
    do begin
      step_position(c, r, q, w, h, emit, last, index);
      n++;
    end while (!last);
    return n;
  endfunction

  function automatic pixel_t pick_pixel();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return pixel_t'($urandom);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  task automatic push_item(logic mode, pixel_t pixel);
    pixel_req_t req;
    req.mode  = mode;
    req.pixel = pixel;
    pending_pixels.push_back(req);
    queued_total++;
  endtask

  task automatic queue_frame(bit broken);
    int unsigned w, h, drain;
    w     = eff_width();
    h     = eff_height();
    drain = broken ? $urandom_range(2 * w + 2) : w + 1;
    repeat (w * h) push_item(($urandom_range(99) < 8) ? MODE_FLUSH : MODE_PIXEL, pick_pixel());
    repeat (drain) push_item(($urandom_range(99) < 85) ? MODE_FLUSH : MODE_PIXEL, pick_pixel());
  endtask

  // Drain whatever is left of the current frame; call only while idle.
  task automatic finish_frame();
    if (frame_col != 0 || frame_row != 0 || result_index != 0)
      repeat (items_to_frame_end())
        push_item(($urandom_range(99) < 80) ? MODE_FLUSH : MODE_PIXEL, pick_pixel());
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || expected_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t index, logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (index == CFG_IMAGE_WIDTH) width_reg = value[WIDTH_BITS-1:0];
    else height_reg = value[HEIGHT_BITS-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(idle_t m);
    case (m)
      IDLE_NONE: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 51;
        stall_pct    = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct    = 51;
      end
      default: begin
        send_gap_pct = 25;
        stall_pct    = 25;
      end
    endcase
  endtask

  always @(posedge clk) begin : sample_channels
    pixel_req_t  req;
    sed_result_t got, want;
    in_fired = !rst && pix_ch.valid && pix_ch.ready;
    if (in_fired) begin
      req = pending_pixels.pop_front();
      predict_edge(req);
      requests_taken++;
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.strength = res_ch.edge_strength;
      got.last     = res_ch.frame_last;
      if (expected_edges.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: edge_strength %0d frame_last %0d",
                                got.strength, got.last));
      end else begin
        want = expected_edges.pop_front();
        edges_checked++;
        if (got.strength !== want.strength)
          flag_mismatch($sformatf("result %0d edge_strength: expected %0d, got %0d",
                                  edges_checked, want.strength, got.strength));
        if (got.last !== want.last)
          flag_mismatch($sformatf("result %0d frame_last: expected %0d, got %0d",
                                  edges_checked, want.last, got.last));
        if (want.last) frames_closed++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
      pix_ch.mode  <= MODE_PIXEL;
      pix_ch.pixel <= '0;
    end else if (!pix_ch.valid || in_fired) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        pix_ch.valid <= 1'b1;
        pix_ch.mode  <= pending_pixels[0].mode;
        pix_ch.pixel <= pending_pixels[0].pixel;
      end else begin
        pix_ch.valid <= 1'b0;
        pix_ch.mode  <= 1'($urandom_range(1));
        pix_ch.pixel <= pixel_t'($urandom);
      end
    end
    res_ch.ready <= !results_held && ($urandom_range(99) >= stall_pct);
  end

  // Hold off results long enough to back up the pipeline into the pixel input.
  initial begin
    wait (hold_request);
    results_held = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    results_held = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** sobel_edge_magnitude: FAILED **");
    $finish;
  end

  initial begin
    pixel_t      pattern [12];
    int unsigned random_start, setting, sel;
    logic [CFG_DATA_BITS-1:0] w_val, h_val;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_IMAGE_WIDTH;
    cfg_ch.data  = '0;
    clear_model();
    set_idling(IDLE_NONE);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Small 4x3 frame of 00/FF pixels with a flush tick mid-frame and a pixel during drain
    pattern = '{8'hFF, 8'h00, 8'hFF, 8'h00,
                8'h00, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'h00, 8'hFF};
    write_reg(CFG_IMAGE_WIDTH, 4);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 12; i++) push_item((i == 6) ? MODE_FLUSH : MODE_PIXEL, pattern[i]);
    push_item(MODE_FLUSH, 8'hFF);
    push_item(MODE_FLUSH, 8'h00);
    push_item(MODE_FLUSH, 8'h55);
    push_item(MODE_PIXEL, 8'h80);
    push_item(MODE_FLUSH, 8'hAA);
    wait_drained();

    // Zero width and height act as one
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    push_item(MODE_PIXEL, 8'hFF);
    push_item(MODE_FLUSH, 8'h00);
    push_item(MODE_FLUSH, 8'hFF);
    wait_drained();

    // Narrow the width in the middle of a frame
    write_reg(CFG_IMAGE_WIDTH, 5);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    repeat (7) push_item(MODE_PIXEL, pick_pixel());
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 3);
    finish_frame();
    wait_drained();

    // Oversized registers, then a narrow width with the column far past the row end
    set_idling(IDLE_BOTH);
    write_reg(CFG_IMAGE_WIDTH, 2047);
    write_reg(CFG_IMAGE_HEIGHT, 8191);
    repeat (40) push_item(MODE_PIXEL, pick_pixel());
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 6);
    write_reg(CFG_IMAGE_HEIGHT, 4);
    finish_frame();
    wait_drained();

    // Back-pressure, then a sender pause mid-frame
    set_idling(IDLE_NONE);
    write_reg(CFG_IMAGE_WIDTH, 12);
    write_reg(CFG_IMAGE_HEIGHT, 12);
    queue_frame(1'b0);
    hold_request = 1'b1;
    wait_drained();
    repeat (70) push_item(MODE_PIXEL, pick_pixel());
    wait_drained();
    finish_frame();
    wait_drained();

    random_start = queued_total;
    setting = 0;
    while (queued_total - random_start < RANDOM_REQUESTS) begin
      if ($urandom_range(4) != 0) begin
        finish_frame();
        wait_drained();
      end
      sel = $urandom_range(99);
      if (sel < 8) w_val = 0;
      else if (sel < 75) w_val = $urandom_range(1, 12);
      else w_val = $urandom_range(13, 40);
      sel = $urandom_range(99);
      h_val = (sel < 8) ? 0 : $urandom_range(1, 9);
      write_reg(CFG_IMAGE_WIDTH, w_val);
      write_reg(CFG_IMAGE_HEIGHT, h_val);
      set_idling(idle_t'(setting % 4));
      repeat ($urandom_range(1, 3)) queue_frame($urandom_range(9) == 0);
      wait_drained();
      setting++;
    end

    $display("Sent %0d pixel requests over %0d register writes;",
             requests_taken, reg_writes);
    $display("checked %0d edge results in %0d closed frames.",
             edges_checked, frames_closed);
    if (mismatches == 0) begin
      $display("** sobel_edge_magnitude: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** sobel_edge_magnitude: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/sed_pkg.sv
design/sed_if.sv
design/sed_ram.sv
design/sed_div.sv
design/sed_kernel.sv
design/sed_ofifo.sv
design/sobel_edge_magnitude.sv
sim/tb_sobel_edge_magnitude.sv
